FILE: design/aioc_pkg.sv
// Shared types, codes and helpers for the arcade I/O controller.
package aioc_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_BUS_WRITE = 2'd0,
    OP_BUS_READ  = 2'd1,
    OP_TICK      = 2'd2,
    OP_IO_RESET  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DIP_A     = 2'd0,
    REG_DIP_B     = 2'd1,
    REG_IRQ_DELAY = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  // Command register codes
  localparam logic [7:0] CMD_SWITCH_MODE  = 8'hA1;
  localparam logic [7:0] CMD_CREDIT_MODE0 = 8'hC1;
  localparam logic [7:0] CMD_CREDIT_MODE1 = 8'hE1;
  localparam logic [7:0] CMD_IRQ_OFF      = 8'h10;
  localparam logic [7:0] CMD_BUTTONS      = 8'h71;
  localparam logic [7:0] CMD_DIPS         = 8'hD2;
  localparam logic [7:0] CMD_ZEROS        = 8'hB1;

  // Read-back constants
  localparam logic [7:0] RD_IDLE      = 8'hFF;
  localparam logic [7:0] RD_IDX2_BYTE = 8'hF8;
  localparam logic [7:0] JOY_UP       = 8'h0F;
  localparam logic [7:0] JOY_RIGHT    = 8'h0D;
  localparam logic [7:0] JOY_DOWN     = 8'h0B;
  localparam logic [7:0] JOY_LEFT     = 8'h09;
  localparam logic [7:0] JOY_NONE     = 8'h07;
  localparam logic [7:0] JOY_FIRE     = 8'h30;

  localparam logic [6:0]  CREDIT_MAX      = 7'd99;
  localparam logic [15:0] IRQ_DELAY_RESET = 16'd32;

  // Button bit positions
  localparam int BTN_COIN  = 0;
  localparam int BTN_START = 1;
  localparam int BTN_UP    = 2;
  localparam int BTN_DOWN  = 3;
  localparam int BTN_LEFT  = 4;
  localparam int BTN_RIGHT = 5;
  localparam int BTN_FIRE  = 6;

  // Binary 0..99 to packed BCD; tens by reciprocal multiply (205/2048)
  function automatic logic [7:0] to_bcd(input logic [6:0] value);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, value} * 15'd205;
    tens = prod[14:11];
    ones = value - 7'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

FILE: design/arcade_io_controller_with_credits.sv
// Top level of the arcade I/O controller: register window, credits and IRQ delay.
//
//  channel | signals                         | direction | content
//  --------+---------------------------------+-----------+-------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser | in      | bus write/read, tick, I/O reset
//  m_*     | m_tvalid m_tready m_tdata        | out       | read byte and IRQ request
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data | in  | DIP banks, IRQ delay
//
// Each item's state update and result are computed in the cycle it is accepted
// and land in the output register on that edge.
// One item per cycle is sustained; s_tready drops only while a result waits
// and m_tready is low. The config port is always ready.
// rst is synchronous; it clears the block state, out_valid and the DIP banks and sets the IRQ delay to 32.
module arcade_io_controller_with_credits
  import aioc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[8:0], write_data[16:9], buttons[23:17]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], irq_request[8], zero[15:9]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [7:0]  dip_switch_a;
  logic [7:0]  dip_switch_b;
  logic [15:0] irq_delay_ticks;

  // Block state; the third history entry never reaches a result, so only two are kept
  logic [7:0]  command_reg, command_reg_next;
  logic        switch_mode, switch_mode_next;
  logic [15:0] irq_countdown, irq_countdown_next;
  logic [6:0]  credit_count, credit_count_next;
  logic [6:0]  hist0, hist1;
  logic        hist_shift;

  // Output register
  logic        out_valid;
  logic [7:0]  read_data, read_data_next;
  logic        irq_request, irq_request_next;

  // Input fields
  op_t         op;
  logic [8:0]  address;
  logic [7:0]  write_data;
  logic [6:0]  buttons;
  logic        accept;

  // Read-path helpers
  logic [3:0]  idx;
  logic [6:0]  pulse;
  logic [6:0]  credit_inc;
  logic [7:0]  sw_bits;
  logic [7:0]  joy_bits;
  logic [7:0]  data_byte;
  logic [15:0] count_dec;

  assign op         = op_t'(s_tuser);
  assign address    = s_tdata[8:0];
  assign write_data = s_tdata[16:9];
  assign buttons    = s_tdata[23:17];
  assign idx        = address[3:0];

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, irq_request, read_data};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_switch_a    <= '0;
      dip_switch_b    <= '0;
      irq_delay_ticks <= IRQ_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_DIP_A:     dip_switch_a    <= cfg_data[7:0];
        REG_DIP_B:     dip_switch_b    <= cfg_data[7:0];
        REG_IRQ_DELAY: irq_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Credit counter: coin edge then start edge, both saturating
  assign pulse = (buttons ^ hist1) & buttons;
  always_comb begin
    credit_inc = credit_count;
    if (buttons[BTN_COIN] && !hist0[BTN_COIN] && credit_count < CREDIT_MAX)
      credit_inc = credit_count + 7'd1;
    credit_count_next = credit_inc;
    if (buttons[BTN_START] && !hist0[BTN_START] && credit_inc != 7'd0)
      credit_count_next = credit_inc - 7'd1;
  end

  // Switch-mode and credit-mode button encodings (active low on return)
  always_comb begin
    sw_bits = '0;
    if (idx == 4'd0) begin
      sw_bits[0] = buttons[BTN_COIN];
      sw_bits[4] = buttons[BTN_START];
    end else begin
      sw_bits[0] = buttons[BTN_UP];
      sw_bits[1] = buttons[BTN_RIGHT];
      sw_bits[2] = buttons[BTN_DOWN];
      sw_bits[3] = buttons[BTN_LEFT];
      sw_bits[4] = pulse[BTN_FIRE];
      sw_bits[5] = hist0[BTN_FIRE];
    end
    if (buttons[BTN_UP])         joy_bits = JOY_UP;
    else if (buttons[BTN_RIGHT]) joy_bits = JOY_RIGHT;
    else if (buttons[BTN_DOWN])  joy_bits = JOY_DOWN;
    else if (buttons[BTN_LEFT])  joy_bits = JOY_LEFT;
    else                         joy_bits = JOY_NONE;
    if (buttons[BTN_FIRE]) joy_bits = joy_bits | JOY_FIRE;
  end

  // Data window read byte
  always_comb begin
    data_byte = RD_IDLE;
    case (command_reg)
      CMD_BUTTONS: begin
        if (switch_mode) begin
          if (idx inside {4'd0, 4'd1}) data_byte = ~sw_bits;
        end else begin
          if (idx == 4'd0)      data_byte = to_bcd(credit_count_next);
          else if (idx == 4'd1) data_byte = ~joy_bits;
          else if (idx == 4'd2) data_byte = RD_IDX2_BYTE;
        end
      end
      CMD_DIPS: begin
        if (idx == 4'd0)      data_byte = ~dip_switch_a;
        else if (idx == 4'd1) data_byte = ~dip_switch_b;
      end
      CMD_ZEROS: begin
        if (idx <= 4'd2) data_byte = 8'h00;
      end
      default: ;
    endcase
  end

  // Per-item state update and result
  assign count_dec = irq_countdown - 16'd1;
  always_comb begin
    command_reg_next   = command_reg;
    switch_mode_next   = switch_mode;
    irq_countdown_next = irq_countdown;
    read_data_next     = RD_IDLE;
    irq_request_next   = 1'b0;
    hist_shift         = 1'b0;
    case (op)
      OP_BUS_WRITE: begin
        if (address[8]) begin
          command_reg_next = write_data;
          if (write_data == CMD_SWITCH_MODE) switch_mode_next = 1'b1;
          if (write_data inside {CMD_CREDIT_MODE0, CMD_CREDIT_MODE1})
            switch_mode_next = 1'b0;
          irq_countdown_next = (write_data != CMD_IRQ_OFF) ? irq_delay_ticks : 16'd0;
        end
      end
      OP_BUS_READ: begin
        if (address[8]) begin
          read_data_next = command_reg;
        end else begin
          read_data_next = data_byte;
          hist_shift     = 1'b1;
        end
      end
      OP_TICK: begin
        if (irq_countdown != 16'd0) begin
          irq_countdown_next = count_dec;
          if (count_dec == 16'd0) begin
            irq_request_next   = 1'b1;
            irq_countdown_next = irq_delay_ticks;
          end
        end
      end
      OP_IO_RESET: begin
        command_reg_next   = '0;
        switch_mode_next   = 1'b0;
        irq_countdown_next = '0;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg   <= '0;
      switch_mode   <= 1'b0;
      irq_countdown <= '0;
      credit_count  <= '0;
      hist0         <= '0;
      hist1         <= '0;
    end else if (accept) begin
      command_reg   <= command_reg_next;
      switch_mode   <= switch_mode_next;
      irq_countdown <= irq_countdown_next;
      if (hist_shift) begin
        credit_count <= credit_count_next;
        hist0        <= buttons;
        hist1        <= hist0;
      end
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= read_data_next;
      irq_request <= irq_request_next;
    end
  end

endmodule
